// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF   = 80;
  localparam int TEXT_ROWS_DEF = 24;
  localparam int TAB_STOP_DEF  = 5;

  localparam logic [7:0] ATTR_RESET = 8'h1F;
  localparam logic [7:0] CH_BLANK   = 8'h20;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
    logic        scrolled;
  } tcw_out_t;

endpackage

// ===== design/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front
// Input queue: two-entry FIFO between the input port and the executor.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tcw_pkg::tcw_in_t in_item,
  output logic            full,
  output logic            q_valid,
  output tcw_pkg::tcw_in_t q_item,
  input  logic            q_take
);
  import tcw_pkg::*;

  tcw_in_t    buf_r [2];
  logic       rp_r, rp_nxt, wp_r, wp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = buf_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_comb begin
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    wp_nxt  = do_push ? ~wp_r : wp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r  <= 1'b0;
      wp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rp_r  <= rp_nxt;
      wp_r  <= wp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      buf_r[wp_r] <= in_item;
    end
  end

endmodule

// ===== design/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back
// Executor: cursor logic, cell store sequencing, scroll and clear sweeps.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int TEXT_ROWS = tcw_pkg::TEXT_ROWS_DEF,
  parameter int TAB_STOP  = tcw_pkg::TAB_STOP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        attr,
  input  logic              q_valid,
  input  tcw_pkg::tcw_in_t  q_item,
  output logic              q_take,
  output logic              res_valid,
  output tcw_pkg::tcw_out_t res_item,
  input  logic              res_ready
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * (TEXT_ROWS + 1);
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS + TAB_STOP + 1);
  localparam int RW    = $clog2(TEXT_ROWS + 1);
  localparam int PW    = $clog2(TAB_STOP + 1);
  localparam int MOVED = COLUMNS * (TEXT_ROWS - 1);
  localparam int TEXT_CELLS = COLUMNS * TEXT_ROWS;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_SCR   = 3'd3;
  localparam logic [2:0] S_BLANK = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_RDW   = 3'd6;

  logic [2:0]    st_r, st_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [PW-1:0] ph_r, ph_nxt;
  logic [AW:0]   ptr_r, ptr_nxt;
  logic [AW:0]   end_r, end_nxt;
  logic          oor_r, oor_nxt;
  logic          cp_r, cp_nxt;
  logic [7:0]    batt_r, batt_nxt;
  tcw_out_t      res_r, res_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;

  logic [CW-1:0] c1, tabc;
  logic [RW-1:0] r1;
  logic [PW-1:0] p1;
  logic [AW-1:0] cur_addr;
  logic [10:0]   pos;

  tcw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign cur_addr = AW'(row_r * COLUMNS + col_r);
  assign pos      = 11'(row_r * COLUMNS + col_r);
  // ph_r tracks the column modulo TAB_STOP
  assign tabc     = CW'(int'(col_r) + TAB_STOP - int'(ph_r));

  assign res_valid = (st_r == S_OUT);
  assign res_item  = res_r;

  always_comb begin
    st_nxt   = st_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    ph_nxt   = ph_r;
    ptr_nxt  = ptr_r;
    end_nxt  = end_r;
    oor_nxt  = oor_r;
    cp_nxt   = 1'b0;
    batt_nxt = batt_r;
    res_nxt  = res_r;
    q_take   = 1'b0;
    we       = 1'b0;
    waddr    = ptr_r[AW-1:0];
    wdata    = {batt_r, CH_BLANK};
    raddr    = ptr_r[AW-1:0];
    c1       = col_r;
    r1       = row_r;
    p1       = ph_r;
    case (st_r)
      S_INIT: begin
        we = 1'b1;
        wdata = {ATTR_RESET, CH_BLANK};
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == (AW+1)'(CELLS - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_take  = 1'b1;
          res_nxt.cell_data = 16'd0;
          res_nxt.scrolled  = 1'b0;
          res_nxt.cursor_position = pos;
          st_nxt = S_OUT;
          case (q_item.operation)
            OP_PUT: begin
              if (q_item.char_code != CH_NUL) begin
                if (q_item.char_code == CH_LF) begin
                  c1 = '0;
                  p1 = '0;
                  r1 = row_r + 1'b1;
                end else if (q_item.char_code == CH_CR) begin
                  c1 = '0;
                  p1 = '0;
                end else if (q_item.char_code == CH_TAB) begin
                  c1 = tabc;
                  p1 = '0;
                end else begin
                  we    = 1'b1;
                  waddr = cur_addr;
                  wdata = {attr, q_item.char_code};
                  c1    = col_r + 1'b1;
                  p1    = (ph_r == PW'(TAB_STOP - 1)) ? '0 : ph_r + 1'b1;
                end
                if (c1 >= CW'(COLUMNS)) begin
                  c1 = '0;
                  p1 = '0;
                  r1 = r1 + 1'b1;
                end
                col_nxt = c1;
                row_nxt = r1;
                ph_nxt  = p1;
                res_nxt.cursor_position = 11'(r1 * COLUMNS + c1);
                if (r1 > RW'(TEXT_ROWS - 1)) begin
                  row_nxt  = RW'(TEXT_ROWS - 1);
                  col_nxt  = '0;
                  ph_nxt   = '0;
                  res_nxt.cursor_position = 11'((TEXT_ROWS - 1) * COLUMNS);
                  res_nxt.scrolled = 1'b1;
                  batt_nxt = attr;
                  ptr_nxt  = '0;
                  st_nxt   = (MOVED > 0) ? S_SCR : S_BLANK;
                  end_nxt  = (AW+1)'(TEXT_CELLS);
                  if (MOVED == 0) begin
                    ptr_nxt = (AW+1)'(MOVED);
                  end
                end
              end
            end
            OP_READ: begin
              oor_nxt = ({1'b0, q_item.cell_index} >= 12'(CELLS));
              ptr_nxt = (AW+1)'(q_item.cell_index);
              st_nxt  = S_RD;
            end
            OP_CLEAR: begin
              col_nxt  = '0;
              row_nxt  = '0;
              ph_nxt   = '0;
              res_nxt.cursor_position = 11'd0;
              batt_nxt = attr;
              ptr_nxt  = '0;
              end_nxt  = (AW+1)'(TEXT_CELLS);
              st_nxt   = S_BLANK;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        raddr  = oor_r ? '0 : ptr_r[AW-1:0];
        st_nxt = S_RDW;
      end
      S_RDW: begin
        res_nxt.cell_data = oor_r ? 16'd0 : rdata;
        st_nxt = S_OUT;
      end
      S_SCR: begin
        // read cell ptr+COLUMNS, write it at ptr in the next cycle
        raddr = AW'(ptr_r + COLUMNS);
        if (cp_r) begin
          we    = 1'b1;
          waddr = AW'(ptr_r - 1'b1);
          wdata = rdata;
        end
        if (ptr_r == (AW+1)'(MOVED)) begin
          st_nxt = S_BLANK;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
          cp_nxt  = 1'b1;
        end
      end
      S_BLANK: begin
        we = 1'b1;
        if (ptr_r + 1'b1 == end_r) begin
          st_nxt = S_OUT;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_OUT: begin
        if (res_ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_INIT;
      col_r <= '0;
      row_r <= '0;
      ph_r  <= '0;
      ptr_r <= '0;
      cp_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      ph_r  <= ph_nxt;
      ptr_r <= ptr_nxt;
      cp_r  <= cp_nxt;
    end
    end_r  <= end_nxt;
    oor_r  <= oor_nxt;
    batt_r <= batt_nxt;
    res_r  <= res_nxt;
  end

endmodule

// ===== design/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: cell store, cursor, scroll and clear.
// ----------------------------------------------------------------------------
// After reset the block fills the cell store, COLUMNS*(TEXT_ROWS+1) cells
// (2000 by default), with blanks before taking the first item. Items pass a
// two-entry input queue to an executor with a single-port-write RAM. The
// executor ends one item before taking the next: a put, NUL or unused op
// writes at most one cell; a read uses the registered RAM read; a clear
// blanks COLUMNS*TEXT_ROWS cells (1920); a put that scrolls copies one cell per
// cycle and then blanks the last row. Each result is held until it is popped.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int TEXT_ROWS = tcw_pkg::TEXT_ROWS_DEF,
  parameter int TAB_STOP  = tcw_pkg::TAB_STOP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  tcw_pkg::tcw_in_t  in_item,
  output logic              empty,
  input  logic              pop,
  output tcw_pkg::tcw_out_t out_item,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);
  import tcw_pkg::*;

  logic [7:0] attr_r;
  logic       q_valid, q_take, res_valid;
  tcw_in_t    q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_we) begin
      attr_r <= cfg_wdata;
    end
  end

  tcw_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .in_item(in_item), .full(full),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  tcw_back #(.COLUMNS(COLUMNS), .TEXT_ROWS(TEXT_ROWS), .TAB_STOP(TAB_STOP)) u_back (
    .clk(clk), .rst_n(rst_n), .attr(attr_r),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
    .res_valid(res_valid), .res_item(out_item), .res_ready(pop)
  );

  assign empty = !res_valid;

endmodule
